// ===== src/tmvc_pkg.sv =====
// Shared constants, codes and palette tables of the minimap viewport colorizer.
package tmvc_pkg;

	localparam int MAP_SIDE_DEF    = 64;
	localparam int VIEW_WIDTH_DEF  = 400;
	localparam int VIEW_HEIGHT_DEF = 200;

	localparam int IDX_W      = 17;
	localparam int CELL_IN_W  = 6;
	localparam int COLOR_W    = 24;
	localparam int PAL_W      = 3;
	localparam int ZOOM_W     = 16;
	localparam int PLAYER_W   = 14;
	localparam int DIM_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic OP_RENDER = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_ZOOM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 3'd5;

	localparam logic [COLOR_W-1:0] MARK_COLOR = 24'h00FF00;

	localparam logic [COLOR_W-1:0] OUTSIDE_TAB [8] = '{
		24'h000000, 24'h883700, 24'h969530, 24'h601312,
		24'h604F12, 24'h605AC0, 24'h000000, 24'h440044};
	localparam logic [COLOR_W-1:0] WALL_TAB [8] = '{
		24'h000000, 24'h443700, 24'h443700, 24'hD58A00,
		24'h634200, 24'hE1E0F9, 24'hFFFFFF, 24'h000033};
	localparam logic [COLOR_W-1:0] FIELD_TAB [8] = '{
		24'h000000, 24'hE1CFA0, 24'hC3E0BA, 24'hFFE4B9,
		24'hE4D1AC, 24'hC6DBFD, 24'h666666, 24'h8822AA};

endpackage

// ===== src/tmvc_ram.sv =====
// Generic single-port RAM with an enable and a registered read.
module tmvc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== src/tile_map_viewport_colorizer_top.sv =====
// Top level of the minimap viewport colorizer: a five-stage pixel pipeline.
// An item passes stages one to four in order, and its result is offered from stage five.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// The row split, the column split, the two zoom multiplies together and the wall map port each own a stage.
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
// The wall map is not cleared by reset and holds no meaning until it is written.
module tile_map_viewport_colorizer_top #(
	parameter int MAP_SIDE    = tmvc_pkg::MAP_SIDE_DEF,
	parameter int VIEW_WIDTH  = tmvc_pkg::VIEW_WIDTH_DEF,
	parameter int VIEW_HEIGHT = tmvc_pkg::VIEW_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tmvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmvc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [tmvc_pkg::IDX_W-1:0]        pixel_index,
	input  logic [tmvc_pkg::CELL_IN_W-1:0]    cell_column,
	input  logic [tmvc_pkg::CELL_IN_W-1:0]    cell_row,
	input  logic                              cell_is_wall,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tmvc_pkg::COLOR_W-1:0]      pixel_color
);

	localparam int IDX_W  = tmvc_pkg::IDX_W;
	localparam int CIN_W  = tmvc_pkg::CELL_IN_W;
	localparam int COL_W  = $clog2(VIEW_WIDTH);
	localparam int ROW_W  = $clog2((2**IDX_W - 1) / VIEW_WIDTH + 1);
	localparam int HGT_W  = $clog2(VIEW_HEIGHT);
	localparam int DX_W   = COL_W + 1;
	localparam int DY_W   = ((ROW_W > HGT_W) ? ROW_W : HGT_W) + 1;
	localparam int PX_W   = DX_W + tmvc_pkg::ZOOM_W + 1;
	localparam int PY_W   = DY_W + tmvc_pkg::ZOOM_W + 1;
	localparam int POS_W  = ((PX_W > PY_W) ? PX_W : PY_W) + 1;
	localparam int CELL_W = POS_W - 8;
	localparam int AW     = $clog2(MAP_SIDE * MAP_SIDE);
	localparam int REC_S  = IDX_W + COL_W;
	localparam int REC_M  = (2**REC_S + VIEW_WIDTH - 1) / VIEW_WIDTH;
	localparam int REC_W  = $clog2(REC_M + 1);

	localparam logic [REC_W-1:0]        RECIP     = REC_W'(REC_M);
	localparam logic signed [DX_W-1:0]  CX_S      = DX_W'(VIEW_WIDTH / 2);
	localparam logic signed [DY_W-1:0]  CY_S      = DY_W'(VIEW_HEIGHT / 2);
	localparam logic signed [POS_W-1:0] TRUNC_BIAS = POS_W'(255);
	localparam logic [8:0]              SIDE_LIM  = 9'(MAP_SIDE);

	// Configuration registers.
	logic [tmvc_pkg::PAL_W-1:0]    palette_q;
	logic [tmvc_pkg::ZOOM_W-1:0]   inverse_zoom_q;
	logic [tmvc_pkg::PLAYER_W-1:0] player_x_q;
	logic [tmvc_pkg::PLAYER_W-1:0] player_y_q;
	logic [tmvc_pkg::DIM_W-1:0]    map_width_q;
	logic [tmvc_pkg::DIM_W-1:0]    map_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q      <= '0;
			inverse_zoom_q <= 16'd256;
			player_x_q     <= '0;
			player_y_q     <= '0;
			map_width_q    <= 7'd64;
			map_height_q   <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmvc_pkg::CFG_PALETTE:      palette_q      <= cfg_data[tmvc_pkg::PAL_W-1:0];
				tmvc_pkg::CFG_INVERSE_ZOOM: inverse_zoom_q <= cfg_data;
				tmvc_pkg::CFG_PLAYER_X:     player_x_q     <= cfg_data[tmvc_pkg::PLAYER_W-1:0];
				tmvc_pkg::CFG_PLAYER_Y:     player_y_q     <= cfg_data[tmvc_pkg::PLAYER_W-1:0];
				tmvc_pkg::CFG_MAP_WIDTH:    map_width_q    <= cfg_data[tmvc_pkg::DIM_W-1:0];
				tmvc_pkg::CFG_MAP_HEIGHT:   map_height_q   <= cfg_data[tmvc_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together unless a finished result is held.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Payload of each stage.
	logic             op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [CIN_W-1:0] wcol_s1, wcol_s2, wcol_s3, wcol_s4;
	logic [CIN_W-1:0] wrow_s1, wrow_s2, wrow_s3, wrow_s4;
	logic             wall_s1, wall_s2, wall_s3, wall_s4;
	logic [ROW_W-1:0] row_s2;
	logic signed [DX_W-1:0] dx_s3;
	logic signed [DY_W-1:0] dy_s3;
	logic             mark_s3, mark_s4, mark_s5;
	logic signed [PX_W-1:0] prod_x_s4;
	logic signed [PY_W-1:0] prod_y_s4;
	logic             outside_s5;

	// Stage one to two: row by reciprocal multiplication.
	logic [IDX_W+REC_W-1:0] row_prod;
	assign row_prod = (IDX_W+REC_W)'(idx_s1) * (IDX_W+REC_W)'(RECIP);

	// Stage two to three: column, offsets from the centre and the centre square.
	logic [IDX_W-1:0]       col_full;
	logic [COL_W-1:0]       col;
	logic signed [DX_W-1:0] dx;
	logic signed [DY_W-1:0] dy;
	logic                   mark;

	assign col_full = idx_s2 - IDX_W'(int'(row_s2) * VIEW_WIDTH);
	assign col      = col_full[COL_W-1:0];
	assign dx       = $signed({1'b0, col}) - CX_S;
	assign dy       = $signed(DY_W'(row_s2)) - CY_S;
	assign mark     = (int'(row_s2) > VIEW_HEIGHT / 2 - 5) && (int'(row_s2) < VIEW_HEIGHT / 2 + 6)
		&& (int'(col) > VIEW_WIDTH / 2 - 5) && (int'(col) < VIEW_WIDTH / 2 + 6);

	// Stage three to four: scale the offsets by the inverse zoom.
	logic signed [PX_W-1:0] prod_x;
	logic signed [PY_W-1:0] prod_y;
	assign prod_x = dx_s3 * $signed({1'b0, inverse_zoom_q});
	assign prod_y = dy_s3 * $signed({1'b0, inverse_zoom_q});

	// Stage four: add the player position, truncate toward zero, check bounds, access the map.
	logic signed [POS_W-1:0]  pos_x, pos_y, adj_x, adj_y;
	logic signed [CELL_W-1:0] cell_x, cell_y;
	logic [8:0]               lim_w, lim_h;
	logic                     in_map;
	logic [AW-1:0]            rd_addr, wr_addr, ram_addr;
	logic                     wr_ok, ram_we, ram_rdata;

	assign pos_x  = POS_W'(prod_x_s4) + POS_W'($signed({1'b0, player_x_q}));
	assign pos_y  = POS_W'(prod_y_s4) + POS_W'($signed({1'b0, player_y_q}));
	assign adj_x  = pos_x + (pos_x[POS_W-1] ? TRUNC_BIAS : '0);
	assign adj_y  = pos_y + (pos_y[POS_W-1] ? TRUNC_BIAS : '0);
	assign cell_x = $signed(adj_x[POS_W-1:8]);
	assign cell_y = $signed(adj_y[POS_W-1:8]);
	assign lim_w  = (9'(map_width_q) < SIDE_LIM) ? 9'(map_width_q) : SIDE_LIM;
	assign lim_h  = (9'(map_height_q) < SIDE_LIM) ? 9'(map_height_q) : SIDE_LIM;
	assign in_map = !cell_x[CELL_W-1] && ($unsigned(cell_x) < CELL_W'(lim_w))
		&& !cell_y[CELL_W-1] && ($unsigned(cell_y) < CELL_W'(lim_h));

	assign rd_addr  = AW'(int'(cell_y[8:0]) * MAP_SIDE + int'(cell_x[8:0]));
	assign wr_addr  = AW'(int'(wrow_s4) * MAP_SIDE + int'(wcol_s4));
	assign wr_ok    = (int'(wcol_s4) < MAP_SIDE) && (int'(wrow_s4) < MAP_SIDE);
	assign ram_addr = (op_s4 == tmvc_pkg::OP_WRITE) ? wr_addr : rd_addr;
	assign ram_we   = adv && valid_s4 && (op_s4 == tmvc_pkg::OP_WRITE) && wr_ok;

	tmvc_ram #(
		.WIDTH(1),
		.DEPTH(MAP_SIDE * MAP_SIDE)
	) u_wall_map (
		.clk  (clk),
		.en   (adv),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wall_s4),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1      <= operation;
			idx_s1     <= pixel_index;
			wcol_s1    <= cell_column;
			wrow_s1    <= cell_row;
			wall_s1    <= cell_is_wall;

			op_s2      <= op_s1;
			idx_s2     <= idx_s1;
			wcol_s2    <= wcol_s1;
			wrow_s2    <= wrow_s1;
			wall_s2    <= wall_s1;
			row_s2     <= row_prod[REC_S +: ROW_W];

			op_s3      <= op_s2;
			wcol_s3    <= wcol_s2;
			wrow_s3    <= wrow_s2;
			wall_s3    <= wall_s2;
			dx_s3      <= dx;
			dy_s3      <= dy;
			mark_s3    <= mark;

			op_s4      <= op_s3;
			wcol_s4    <= wcol_s3;
			wrow_s4    <= wrow_s3;
			wall_s4    <= wall_s3;
			prod_x_s4  <= prod_x;
			prod_y_s4  <= prod_y;
			mark_s4    <= mark_s3;

			op_s5      <= op_s4;
			mark_s5    <= mark_s4;
			outside_s5 <= !in_map;
		end
	end

	// Stage five: colour from the palette tables or the centre mark colour; write items leave no result.
	assign out_valid   = valid_s5 && (op_s5 == tmvc_pkg::OP_RENDER);
	assign pixel_color = mark_s5    ? tmvc_pkg::MARK_COLOR :
	                     outside_s5 ? tmvc_pkg::OUTSIDE_TAB[palette_q] :
	                     ram_rdata  ? tmvc_pkg::WALL_TAB[palette_q] :
	                                  tmvc_pkg::FIELD_TAB[palette_q];

	a_mark_green: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mark_s5 |-> pixel_color == tmvc_pkg::MARK_COLOR)
		else $error("Centre square pixel is not green.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(valid_s4) && $stable(valid_s5))
		else $error("Pipeline moved while a result was stalled.");

	a_no_palette_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mark_s5 && palette_q == '0 |-> pixel_color == '0)
		else $error("Palette zero gave a non-zero colour.");

endmodule
